/* rtl/core/i2cts_pkg.sv */
// ----------------------------------------------------------------------------
// i2cts_pkg
// Shared types and codes of the I2C register transaction sequencer.
// ----------------------------------------------------------------------------
package i2cts_pkg;

  localparam int CmdW    = 3;
  localparam int ActW    = 3;
  localparam int DevW    = 7;
  localparam int ByteW   = 8;
  localparam int TickW   = 16;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  localparam logic [TickW-1:0] TimeoutReset = 16'd1000;
  localparam logic [CfgAddrW-1:0] RegTimeoutAddr = 3'd0;

  localparam logic [ByteW-1:0] StMask     = 8'hF8;
  localparam logic [ByteW-1:0] StStart    = 8'h08;
  localparam logic [ByteW-1:0] StRstart   = 8'h10;
  localparam logic [ByteW-1:0] StSlaWAck  = 8'h18;
  localparam logic [ByteW-1:0] StDataAck  = 8'h28;
  localparam logic [ByteW-1:0] StSlaRAck  = 8'h40;
  localparam logic [ByteW-1:0] ReadBit    = 8'h01;

  typedef enum logic [CmdW-1:0] {
    CMD_BEGIN_WRITE = 3'd0,
    CMD_BEGIN_READ  = 3'd1,
    CMD_BEGIN_PROBE = 3'd2,
    CMD_SUPPLY      = 3'd3,
    CMD_ENGINE_DONE = 3'd4,
    CMD_TICK        = 3'd5
  } cmd_t;

  typedef enum logic [ActW-1:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_SEND  = 3'd2,
    ACT_RACK  = 3'd3,
    ACT_RNACK = 3'd4,
    ACT_STOP  = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_PROBE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [ByteW-1:0] action_byte;
    logic             need_data;
    logic             read_valid;
    logic [ByteW-1:0] read_byte;
    logic             done_res;
    logic             error;
    logic             present;
  } res_t;

endpackage

/* rtl/core/i2cts_if.sv */
// ----------------------------------------------------------------------------
// i2cts_if
// Valid/ready channels: event input and result output of the sequencer.
// ----------------------------------------------------------------------------
interface i2cts_in_if;
  logic                        valid;
  logic                        ready;
  logic [i2cts_pkg::CmdW-1:0]  command;
  logic [i2cts_pkg::DevW-1:0]  device_address;
  logic [i2cts_pkg::ByteW-1:0] register_address;
  logic [i2cts_pkg::ByteW-1:0] byte_count;
  logic [i2cts_pkg::ByteW-1:0] write_data;
  logic [i2cts_pkg::ByteW-1:0] engine_status;
  logic [i2cts_pkg::ByteW-1:0] received_byte;

  modport source (output valid, command, device_address, register_address, byte_count,
                  write_data, engine_status, received_byte, input ready);
  modport sink   (input valid, command, device_address, register_address, byte_count,
                  write_data, engine_status, received_byte, output ready);
endinterface

interface i2cts_out_if;
  logic                        valid;
  logic                        ready;
  logic [i2cts_pkg::ActW-1:0]  action;
  logic [i2cts_pkg::ByteW-1:0] action_byte;
  logic                        need_data;
  logic                        read_valid;
  logic [i2cts_pkg::ByteW-1:0] read_byte;
  logic                        done_res;
  logic                        error;
  logic                        present;

  modport source (output valid, action, action_byte, need_data, read_valid, read_byte,
                  done_res, error, present, input ready);
  modport sink   (input valid, action, action_byte, need_data, read_valid, read_byte,
                  done_res, error, present, output ready);
endinterface

/* rtl/core/i2c_register_transaction_sequencer_top.sv */
// ----------------------------------------------------------------------------
// i2c_register_transaction_sequencer_top
// Steps register write/read/probe transactions over a byte-level I2C engine.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            contents
//  in_ch     in         valid/ready          command and event fields
//  out_ch    out        valid/ready          engine action, data, done flags
//  cfg_*     in         APB write/read       timeout_ticks at address 0
//
//  One event is accepted per cycle while in_ch is ready; any result is
//  registered, into the skid entry instead while out_ch is stalled.
//  A two-entry output (result register plus skid) keeps in_ch ready while
//  one result waits; in_ch stalls only when both entries are full.
//  Synchronous active-low reset returns to idle with timeout_ticks = 1000.
// ----------------------------------------------------------------------------
module i2c_register_transaction_sequencer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  i2cts_in_if.sink                         in_ch,
  i2cts_out_if.source                      out_ch,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [i2cts_pkg::CfgAddrW-1:0]   cfg_paddr,
  input  logic [i2cts_pkg::CfgDataW-1:0]   cfg_pwdata,
  output logic [i2cts_pkg::CfgDataW-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START  = 4'd1,
    PH_SLAW   = 4'd2,
    PH_REG    = 4'd3,
    PH_NEED   = 4'd4,
    PH_WDATA  = 4'd5,
    PH_RSTART = 4'd6,
    PH_SLAR   = 4'd7,
    PH_RDATA  = 4'd8
  } phase_t;

  phase_t                           phase_r, phase_nxt;
  i2cts_pkg::kind_t                 kind_r, kind_nxt;
  logic [i2cts_pkg::DevW-1:0]       dev_r, dev_nxt;
  logic [i2cts_pkg::ByteW-1:0]      reg_r, reg_nxt;
  logic [i2cts_pkg::ByteW-1:0]      remain_r, remain_nxt;
  logic [i2cts_pkg::TickW-1:0]      wait_r, wait_nxt;
  logic [i2cts_pkg::TickW-1:0]      timeout_r;

  i2cts_pkg::res_t                  res;
  logic                             res_v;
  i2cts_pkg::res_t                  out_res_r, skid_res_r;
  logic                             out_valid_r, skid_valid_r;

  logic                             in_acc;
  logic                             cfg_wr;
  logic                             busy;
  logic [i2cts_pkg::ByteW-1:0]      sla;
  logic [i2cts_pkg::ByteW-1:0]      st;
  logic [i2cts_pkg::ByteW-1:0]      expected;
  logic [i2cts_pkg::ByteW-1:0]      remain_dec;
  logic [i2cts_pkg::TickW-1:0]      wait_inc;

  assign in_ch.ready = !skid_valid_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg_pready  = 1'b1;
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                       (cfg_paddr == i2cts_pkg::RegTimeoutAddr);
  assign cfg_prdata  = (cfg_paddr == i2cts_pkg::RegTimeoutAddr) ?
                       {{(i2cts_pkg::CfgDataW-i2cts_pkg::TickW){1'b0}}, timeout_r} : '0;

  assign busy       = (phase_r != PH_IDLE) && (phase_r != PH_NEED);
  assign sla        = {dev_r, 1'b0};
  assign st         = in_ch.engine_status & i2cts_pkg::StMask;
  assign remain_dec = remain_r - 8'd1;
  assign wait_inc   = (wait_r != '1) ? wait_r + 16'd1 : wait_r;

  always_comb begin
    unique case (phase_r)
      PH_START:  expected = i2cts_pkg::StStart;
      PH_SLAW:   expected = i2cts_pkg::StSlaWAck;
      PH_REG:    expected = i2cts_pkg::StDataAck;
      PH_WDATA:  expected = i2cts_pkg::StDataAck;
      PH_RSTART: expected = i2cts_pkg::StRstart;
      PH_SLAR:   expected = i2cts_pkg::StSlaRAck;
      default:   expected = '0;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    dev_nxt    = dev_r;
    reg_nxt    = reg_r;
    remain_nxt = remain_r;
    wait_nxt   = wait_r;
    res        = '0;
    res_v      = 1'b0;
    unique case (in_ch.command)
      i2cts_pkg::CMD_BEGIN_WRITE, i2cts_pkg::CMD_BEGIN_READ,
      i2cts_pkg::CMD_BEGIN_PROBE: begin
        if (phase_r == PH_IDLE) begin
          res_v      = 1'b1;
          kind_nxt   = i2cts_pkg::kind_t'(in_ch.command[1:0]);
          dev_nxt    = in_ch.device_address;
          reg_nxt    = in_ch.register_address;
          remain_nxt = (in_ch.command == i2cts_pkg::CMD_BEGIN_PROBE) ? '0 : in_ch.byte_count;
          res.action = i2cts_pkg::ACT_START;
          phase_nxt  = PH_START;
          wait_nxt   = '0;
        end
      end
      i2cts_pkg::CMD_SUPPLY: begin
        if (phase_r == PH_NEED) begin
          res_v           = 1'b1;
          remain_nxt      = remain_dec;
          res.action      = i2cts_pkg::ACT_SEND;
          res.action_byte = in_ch.write_data;
          phase_nxt       = PH_WDATA;
          wait_nxt        = '0;
        end
      end
      i2cts_pkg::CMD_ENGINE_DONE: begin
        if (busy) begin
          res_v    = 1'b1;
          wait_nxt = '0;
          if (phase_r == PH_RDATA) begin
            res.read_valid = 1'b1;
            res.read_byte  = in_ch.received_byte;
            remain_nxt     = remain_dec;
            if (remain_dec == '0) begin
              res.action = i2cts_pkg::ACT_STOP;
              res.done_res = 1'b1;
              phase_nxt  = PH_IDLE;
            end else begin
              res.action = (remain_dec > 8'd1) ? i2cts_pkg::ACT_RACK : i2cts_pkg::ACT_RNACK;
            end
          end else if (kind_r == i2cts_pkg::KIND_PROBE && phase_r == PH_SLAW) begin
            res.action   = i2cts_pkg::ACT_STOP;
            res.done_res = 1'b1;
            res.present  = (st == i2cts_pkg::StSlaWAck);
            phase_nxt    = PH_IDLE;
          end else if (st != expected) begin
            res.action   = i2cts_pkg::ACT_STOP;
            res.done_res = 1'b1;
            res.error    = 1'b1;
            phase_nxt    = PH_IDLE;
          end else begin
            unique case (phase_r)
              PH_START: begin
                res.action      = i2cts_pkg::ACT_SEND;
                res.action_byte = sla;
                phase_nxt       = PH_SLAW;
              end
              PH_SLAW: begin
                res.action      = i2cts_pkg::ACT_SEND;
                res.action_byte = reg_r;
                phase_nxt       = PH_REG;
              end
              PH_RSTART: begin
                res.action      = i2cts_pkg::ACT_SEND;
                res.action_byte = sla | i2cts_pkg::ReadBit;
                phase_nxt       = PH_SLAR;
              end
              PH_REG, PH_WDATA: begin
                if (phase_r == PH_REG && kind_r == i2cts_pkg::KIND_READ) begin
                  res.action = i2cts_pkg::ACT_START;
                  phase_nxt  = PH_RSTART;
                end else if (remain_r == '0) begin
                  res.action   = i2cts_pkg::ACT_STOP;
                  res.done_res = 1'b1;
                  phase_nxt    = PH_IDLE;
                end else begin
                  res.action    = i2cts_pkg::ACT_NONE;
                  res.need_data = 1'b1;
                  phase_nxt     = PH_NEED;
                end
              end
              default: begin
                if (remain_r == '0) begin
                  res.action   = i2cts_pkg::ACT_STOP;
                  res.done_res = 1'b1;
                  phase_nxt    = PH_IDLE;
                end else begin
                  res.action = (remain_r > 8'd1) ? i2cts_pkg::ACT_RACK : i2cts_pkg::ACT_RNACK;
                  phase_nxt  = PH_RDATA;
                end
              end
            endcase
          end
        end
      end
      i2cts_pkg::CMD_TICK: begin
        if (busy) begin
          if (wait_inc >= timeout_r) begin
            res_v        = 1'b1;
            res.action   = i2cts_pkg::ACT_STOP;
            res.done_res = 1'b1;
            res.error    = 1'b1;
            phase_nxt    = PH_IDLE;
            wait_nxt     = '0;
          end else begin
            wait_nxt = wait_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      kind_r    <= i2cts_pkg::KIND_WRITE;
      dev_r     <= '0;
      reg_r     <= '0;
      remain_r  <= '0;
      wait_r    <= '0;
      timeout_r <= i2cts_pkg::TimeoutReset;
    end else begin
      if (cfg_wr) begin
        timeout_r <= cfg_pwdata[i2cts_pkg::TickW-1:0];
      end
      if (in_acc) begin
        phase_r  <= phase_nxt;
        kind_r   <= kind_nxt;
        dev_r    <= dev_nxt;
        reg_r    <= reg_nxt;
        remain_r <= remain_nxt;
        wait_r   <= wait_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc && res_v;
      end
    end else if (in_acc && res_v) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      out_res_r <= skid_valid_r ? skid_res_r : res;
    end else if (in_acc && res_v) begin
      skid_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.action      = out_res_r.action;
  assign out_ch.action_byte = out_res_r.action_byte;
  assign out_ch.need_data   = out_res_r.need_data;
  assign out_ch.read_valid  = out_res_r.read_valid;
  assign out_ch.read_byte   = out_res_r.read_byte;
  assign out_ch.done_res    = out_res_r.done_res;
  assign out_ch.error       = out_res_r.error;
  assign out_ch.present     = out_res_r.present;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a result in the output register");

  a_done_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.done_res |-> out_res_r.action == i2cts_pkg::ACT_STOP)
    else $error("done result without stop action");

  a_idle_wait_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> wait_r == '0)
    else $error("wait counter running while idle");

  a_begin_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == PH_IDLE &&
    (in_ch.command == i2cts_pkg::CMD_BEGIN_WRITE ||
     in_ch.command == i2cts_pkg::CMD_BEGIN_READ ||
     in_ch.command == i2cts_pkg::CMD_BEGIN_PROBE) |=> phase_r == PH_START)
    else $error("begin transaction did not enter start phase");

  a_need_no_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.need_data |-> out_res_r.action == i2cts_pkg::ACT_NONE)
    else $error("data request carries an engine action");
`endif

endmodule
